>>> hdl/rqs_pkg.sv
// Shared constants and types for the record quicksort block.
// No dependencies; imported by record_quicksort_lomuto.
package rqs_pkg;
  localparam int MAX_RECORDS = 64;
  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = IDX_W + 1;
  localparam int REC_W = 64;
  localparam int RANGE_W = 2 * IDX_W;
  localparam int TOTAL_W = 12;
  localparam logic [TOTAL_W-1:0] COUNT_MAX = 12'd4095;

  localparam logic [1:0] MODE_ASC_CODE  = 2'd0;
  localparam logic [1:0] MODE_DESC_CODE = 2'd1;
  localparam logic [1:0] MODE_PRICE     = 2'd2;

  typedef logic [REC_W-1:0] rec_t;

  // Element-before-pivot test for the selected mode.
  function automatic logic precedes(input rec_t a, input rec_t p, input logic [1:0] mode);
    logic signed [31:0] ca;
    logic signed [31:0] cp;
    logic [31:0] pa;
    logic [31:0] pp;
    ca = a[63:32];
    cp = p[63:32];
    pa = a[31:0];
    pp = p[31:0];
    case (mode)
      MODE_DESC_CODE: precedes = ca > cp;
      MODE_PRICE:     precedes = (pa != pp) ? (pa < pp) : (ca < cp);
      default:        precedes = ca < cp;
    endcase
  endfunction
endpackage

>>> hdl/rqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/record_quicksort_lomuto.sv
// Record sorter: loads records (code, price) one per beat until a beat marked
// last, then sorts them in place by Lomuto quicksort, then streams them out.
// The sort runs out of one record RAM (one read, one write per cycle) and a
// range-stack RAM: each partition scan step reads and compares an element,
// and a swap adds a write-back and a write; each range adds a pop, a pivot
// fetch, the final swap and the pushes. Each record is read and then put in
// the output register, stalling while the receiver is not ready.
// No input is taken while sorting or emitting. Uses rqs_pkg and rqs_ram.
module record_quicksort_lomuto (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] item_code,
  input  logic [31:0] item_price,
  input  logic        item_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_code,
  output logic [31:0] out_price,
  output logic        out_last,
  output logic [rqs_pkg::TOTAL_W-1:0] comparison_count
);
  import rqs_pkg::*;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_POP   = 4'd1;
  localparam logic [3:0] S_RNG   = 4'd2;
  localparam logic [3:0] S_PIV   = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_SWB   = 4'd6;
  localparam logic [3:0] S_SWW   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_FINW  = 4'd9;
  localparam logic [3:0] S_PUSH  = 4'd10;
  localparam logic [3:0] S_ORD   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]         state;
  logic [1:0]         sort_mode;
  logic [CNT_W-1:0]   record_count;
  logic [CNT_W-1:0]   stack_depth;
  logic [TOTAL_W-1:0] compare_total;
  logic [IDX_W-1:0]   partition_scan;
  logic [CNT_W-1:0]   partition_boundary;
  logic [IDX_W-1:0]   lo;
  logic [IDX_W-1:0]   hi;
  logic [CNT_W-1:0]   out_idx;
  rec_t               pivot;
  rec_t               held;
  logic               push_second;

  logic               rec_we;
  logic [IDX_W-1:0]   rec_waddr;
  rec_t               rec_wdata;
  logic [IDX_W-1:0]   rec_raddr;
  rec_t               rec_rdata;
  logic               stk_we;
  logic [IDX_W-1:0]   stk_waddr;
  logic [RANGE_W-1:0] stk_wdata;
  logic [IDX_W-1:0]   stk_raddr;
  logic [RANGE_W-1:0] stk_rdata;

  rqs_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );
  rqs_ram #(.WIDTH(RANGE_W), .DEPTH(MAX_RECORDS)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  logic in_fire;
  logic out_fire;
  logic [CNT_W-1:0] pb1;
  logic [IDX_W-1:0] pb_idx;
  assign cfg_ready = (state == S_LOAD);
  assign in_ready  = (state == S_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign pb1       = partition_boundary + 1'b1;
  assign pb_idx    = partition_boundary[IDX_W-1:0];

  // Pushes of the right subrange then the left one after a partition.
  logic push_r_ok;
  logic push_l_ok;
  assign push_r_ok = (pb1 < {1'b0, hi});
  assign push_l_ok = (partition_boundary >= ({1'b0, lo} + 2'd2));

  // Memory port steering. A write and a read of the same entry in one cycle
  // return the old contents, which the swaps rely on.
  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = pb_idx;
    rec_wdata = held;
    rec_raddr = partition_scan;
    stk_we    = 1'b0;
    stk_waddr = stack_depth[IDX_W-1:0];
    stk_wdata = {hi, pb1[IDX_W-1:0]};
    stk_raddr = stack_depth[IDX_W-1:0] - 1'b1;
    unique case (state)
      S_LOAD: begin
        rec_we    = in_fire && (record_count < CNT_W'(MAX_RECORDS));
        rec_waddr = record_count[IDX_W-1:0];
        rec_wdata = {item_code, item_price};
        stk_we    = in_fire && item_last && (record_count != '0);
        stk_waddr = '0;
        stk_wdata = {(record_count < CNT_W'(MAX_RECORDS)) ? record_count[IDX_W-1:0]
                     : IDX_W'(MAX_RECORDS - 1), {IDX_W{1'b0}}};
      end
      S_PIV:  rec_raddr = hi;
      S_RD:   rec_raddr = partition_scan;
      S_SWB: begin
        rec_we    = 1'b1;
        rec_waddr = pb_idx;
        rec_wdata = held;
        rec_raddr = pb_idx;
      end
      S_SWW: begin
        rec_we    = 1'b1;
        rec_waddr = partition_scan;
        rec_wdata = rec_rdata;
      end
      S_FIN: begin
        rec_we    = 1'b1;
        rec_waddr = pb_idx;
        rec_wdata = pivot;
        rec_raddr = pb_idx;
      end
      S_FINW: begin
        rec_we    = 1'b1;
        rec_waddr = hi;
        rec_wdata = rec_rdata;
      end
      S_PUSH: begin
        stk_we    = push_second ? push_l_ok : push_r_ok;
        stk_wdata = push_second ? {pb_idx - 1'b1, lo} : {hi, pb1[IDX_W-1:0]};
      end
      S_ORD:  rec_raddr = out_idx[IDX_W-1:0];
      default: ;
    endcase
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_LOAD;
      sort_mode          <= MODE_ASC_CODE;
      record_count       <= '0;
      stack_depth        <= '0;
      compare_total      <= '0;
      partition_scan     <= '0;
      partition_boundary <= '0;
      out_idx            <= '0;
      out_valid          <= 1'b0;
      push_second        <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (cfg_valid) begin
            sort_mode <= cfg_data;
          end
          if (in_fire) begin
            logic [CNT_W-1:0] n;
            n = (record_count < CNT_W'(MAX_RECORDS)) ? record_count + 1'b1 : record_count;
            record_count <= n;
            if (item_last) begin
              compare_total <= '0;
              stack_depth   <= (n >= 2) ? CNT_W'(1) : '0;
              state         <= (n >= 2) ? S_POP : S_ORD;
              out_idx       <= '0;
            end
          end
        end
        S_POP: begin
          if (stack_depth == '0) begin
            state   <= S_ORD;
            out_idx <= '0;
          end else begin
            stack_depth <= stack_depth - 1'b1;
            state       <= S_RNG;
          end
        end
        S_RNG: begin
          lo <= stk_rdata[IDX_W-1:0];
          hi <= stk_rdata[RANGE_W-1:IDX_W];
          partition_scan     <= stk_rdata[IDX_W-1:0];
          partition_boundary <= {1'b0, stk_rdata[IDX_W-1:0]};
          if ({1'b0, stk_rdata[RANGE_W-1:IDX_W]} >= record_count ||
              stk_rdata[IDX_W-1:0] >= stk_rdata[RANGE_W-1:IDX_W]) begin
            state <= S_POP;
          end else begin
            state <= S_PIV;
          end
        end
        S_PIV: state <= S_RD;
        S_RD: begin
          if (partition_scan == lo) begin
            pivot <= rec_rdata;
          end
          state <= S_CMP;
        end
        S_CMP: begin
          if (compare_total != COUNT_MAX) begin
            compare_total <= compare_total + 1'b1;
          end
          if (precedes(rec_rdata, pivot, sort_mode)) begin
            held  <= rec_rdata;
            state <= S_SWB;
          end else if (partition_scan + 1'b1 == hi) begin
            state <= S_FIN;
          end else begin
            partition_scan <= partition_scan + 1'b1;
            state          <= S_RD;
          end
        end
        S_SWB: state <= S_SWW;
        S_SWW: begin
          // The old boundary element moves to the scan slot this cycle.
          partition_boundary <= pb1;
          if (partition_scan + 1'b1 == hi) begin
            state <= S_FIN;
          end else begin
            partition_scan <= partition_scan + 1'b1;
            state          <= S_RD;
          end
        end
        S_FIN: state <= S_FINW;
        S_FINW: begin
          push_second <= 1'b0;
          state       <= S_PUSH;
        end
        S_PUSH: begin
          if (push_second ? push_l_ok : push_r_ok) begin
            stack_depth <= stack_depth + 1'b1;
          end
          push_second <= ~push_second;
          if (push_second) begin
            state <= S_POP;
          end
        end
        S_ORD: begin
          if (!out_valid || out_fire) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_idx   <= out_idx + 1'b1;
          if (out_idx + 1'b1 == record_count) begin
            state        <= S_LOAD;
            record_count <= '0;
          end else begin
            state <= S_ORD;
          end
        end
        default: state <= S_LOAD;
      endcase
      if (out_fire && state != S_OUT) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      out_code         <= rec_rdata[63:32];
      out_price        <= rec_rdata[31:0];
      out_last         <= (out_idx + 1'b1 == record_count);
      comparison_count <= compare_total;
    end
  end

  // Input is never taken while sorting or emitting.
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !in_ready) else $error("input ready while busy");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_depth <= CNT_W'(MAX_RECORDS)) else $error("range stack overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_code)))
    else $error("output beat dropped");
endmodule
